[rtl/core/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, codes and saturation helpers shared by the disk collision block.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // Command kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_TICK    = 2'd0;
    localparam logic [1:0] STAT_ADDED   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_CLEARED = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_WALL_LEFT   = 2'd0;
    localparam logic [1:0] CFG_WALL_TOP    = 2'd1;
    localparam logic [1:0] CFG_WALL_RIGHT  = 2'd2;
    localparam logic [1:0] CFG_WALL_BOTTOM = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [23:0] new_pos_x;
        logic signed [23:0] new_pos_y;
        logic signed [15:0] new_vel_x;
        logic signed [15:0] new_vel_y;
    } cmd_t;

    typedef struct packed {
        logic [3:0]         disk_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [1:0]         status;
        logic               last;
    } result_t;

    // One table entry
    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
    } disk_t;

    // Clamp a wide value into a 16 bit velocity
    function automatic logic signed [15:0] sat_vel(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767)
            r = 16'sh7fff;
        else if (v < -40'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Clamp a wide value into a 24 bit position
    function automatic logic signed [23:0] sat_pos(input logic signed [39:0] v);
        logic signed [23:0] r;
        if (v > 40'sd8388607)
            r = 24'sh7fffff;
        else if (v < -40'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

[rtl/core/bbc_ram.sv]
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/bouncing_ball_collision_step.sv]
// ----------------------------------------------------------------------------
// bouncing_ball_collision_step
// Equal-disk arena: add, clear and tick commands over a table of disks, with
// wall bounce and pairwise elastic collision on one shared arithmetic unit.
// ----------------------------------------------------------------------------
//  Channel   Signals                                Transfer when
//  command   start, busy, cmd                       start && !busy
//  result    result_valid, result                   result_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid && cfg_ready
//
//  Add and clear are done in the idle state; their result shows the cycle after.
//  A tick moves and reports each disk and visits every pair: a pair that is
//  plainly apart is dropped after the delta check, one near but out of reach
//  after the squared-distance check, and a touching pair runs 8 load and
//  square steps, 25 root steps, two divides, ten product steps and 4
//  write-back steps. Reset clears the disk count and loads the default walls;
//  the table is not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module bouncing_ball_collision_step #(
    parameter int MAX_BALLS = 16,
    parameter int DIAMETER  = 30,
    parameter int FRAC_BITS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bbc_pkg::cmd_t    cmd,
    output logic             result_valid,
    output bbc_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    import bbc_pkg::*;

    localparam int    AW     = $clog2(MAX_BALLS);
    localparam int    CW     = $clog2(MAX_BALLS + 1);
    localparam int    DISK_W = $bits(disk_t);
    localparam longint DIA_L = longint'(DIAMETER) << FRAC_BITS;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam longint DIA_SQ = DIA_L * DIA_L;
    localparam int    SQ_W   = 50;
    localparam int    QW     = 17;

    typedef enum logic [4:0] {
        S_IDLE, S_MV_RD, S_MV_WR,
        S_P_RDI, S_P_RDJ, S_P_LDJ, S_P_DELTA, S_P_SQX, S_P_SQY, S_P_D2, S_P_CHK,
        S_P_SQRT, S_P_SQRND, S_P_DIVI, S_P_DIV, S_P_DIVE,
        S_P_M0, S_P_M1, S_P_M2, S_P_M3, S_P_M4, S_P_M5, S_P_M6, S_P_M7, S_P_M8,
        S_P_M9, S_P_UPD, S_P_WRI, S_P_WRJ, S_P_NEXT,
        S_RP_RD, S_RP_OUT
    } state_t;

    state_t state_reg;

    logic signed [15:0] wall_l_reg, wall_t_reg, wall_r_reg, wall_b_reg;
    logic [CW-1:0]      count_reg, k_reg, i_reg, j_reg;
    disk_t              pi_reg, pj_reg;
    logic signed [25:0] dx_reg, dy_reg;
    logic signed [53:0] prod_reg;
    logic signed [55:0] acc_reg;
    logic [SQ_W-1:0]    sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [25:0]        dist_reg;
    logic [26:0]        dv_rem_reg;
    logic [QW-1:0]      dv_low_reg, dv_q_reg;
    logic [4:0]         dv_cnt_reg;
    logic               dv_neg_reg, dv_sel_reg;
    logic signed [17:0] nx_reg, ny_reg;
    logic signed [20:0] v1n_reg;
    logic signed [21:0] dvn_reg;
    logic signed [26:0] s2_reg;
    logic signed [23:0] cx_reg, cy_reg;
    logic signed [27:0] sx_reg, sy_reg;
    result_t            result_reg;
    logic               result_valid_reg;

    // RAM port signals
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    disk_t             ram_wdata;
    logic [DISK_W-1:0] ram_rdata;
    disk_t             rd_disk;

    bbc_ram #(
        .WIDTH(DISK_W),
        .DEPTH(MAX_BALLS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_disk      = disk_t'(ram_rdata);
    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Move one axis: step, bounce off walls, clamp into the arena
    function automatic logic [55:0] move_axis(input logic signed [23:0] p,
                                              input logic signed [15:0] v,
                                              input logic signed [15:0] wlo,
                                              input logic signed [15:0] whi);
        logic signed [39:0] x, lo, hw, hi;
        logic signed [15:0] vn;
        logic signed [23:0] pn;
        x  = 40'(p) + 40'(v);
        lo = 40'(wlo) <<< FRAC_BITS;
        hw = 40'(whi) <<< FRAC_BITS;
        hi = hw - 40'(DIA_L);
        vn = v;
        if (x < lo || x + 40'(DIA_L) > hw)
            vn = sat_vel(-40'(v));
        if (x > hi)
            x = hi;
        if (x < lo)
            x = lo;
        pn = sat_pos(x);
        return {16'(vn), 24'(pn), 16'd0};
    endfunction

    logic [55:0]        mv_x, mv_y;
    disk_t              moved;
    logic signed [26:0] mul_a, mul_b;
    logic signed [53:0] mul_p;
    logic signed [55:0] sum_rnd16, prod_rnd16, prod_rnd17;
    logic [SQ_W-1:0]    sq_t;
    logic [27:0]        dv_t;
    logic [24:0]        abs_d;
    logic [41:0]        dv_num;
    logic signed [17:0] q_s;
    logic [CW:0]        k_inc, i_inc2, j_inc, n_ext;

    // Wall move of the disk just read
    always_comb
    begin
        mv_x = move_axis(rd_disk.pos_x, rd_disk.vel_x, wall_l_reg, wall_r_reg);
        mv_y = move_axis(rd_disk.pos_y, rd_disk.vel_y, wall_t_reg, wall_b_reg);
        moved.pos_x = mv_x[39:16];
        moved.vel_x = mv_x[55:40];
        moved.pos_y = mv_y[39:16];
        moved.vel_y = mv_y[55:40];
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_P_SQX:
            begin
                mul_a = 27'(dx_reg);
                mul_b = 27'(dx_reg);
            end
            S_P_SQY:
            begin
                mul_a = 27'(dy_reg);
                mul_b = 27'(dy_reg);
            end
            S_P_M0:
            begin
                mul_a = 27'(pi_reg.vel_x);
                mul_b = 27'(nx_reg);
            end
            S_P_M1:
            begin
                mul_a = 27'(pi_reg.vel_y);
                mul_b = 27'(ny_reg);
            end
            S_P_M2:
            begin
                mul_a = 27'(pj_reg.vel_x);
                mul_b = 27'(nx_reg);
            end
            S_P_M3:
            begin
                mul_a = 27'(pj_reg.vel_y);
                mul_b = 27'(ny_reg);
            end
            S_P_M5:
            begin
                mul_a = 27'(dvn_reg);
                mul_b = 27'(nx_reg);
            end
            S_P_M6:
            begin
                mul_a = 27'(dvn_reg);
                mul_b = 27'(ny_reg);
            end
            S_P_M7:
            begin
                mul_a = s2_reg;
                mul_b = 27'(nx_reg);
            end
            S_P_M8:
            begin
                mul_a = s2_reg;
                mul_b = 27'(ny_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p      = mul_a * mul_b;
    assign sum_rnd16  = (acc_reg + 56'(prod_reg) + 56'sd32768) >>> 16;
    assign prod_rnd16 = (56'(prod_reg) + 56'sd32768) >>> 16;
    assign prod_rnd17 = (56'(prod_reg) + 56'sd65536) >>> 17;
    assign sq_t       = sq_r_reg + sq_bit_reg;
    assign dv_t       = {dv_rem_reg, dv_low_reg[QW-1]};
    assign q_s        = $signed({1'b0, dv_q_reg});
    assign k_inc      = (CW+1)'(k_reg) + (CW+1)'(1);
    assign i_inc2     = (CW+1)'(i_reg) + (CW+1)'(2);
    assign j_inc      = (CW+1)'(j_reg) + (CW+1)'(1);
    assign n_ext      = (CW+1)'(count_reg);

    // Divider numerator: |d| scaled to Q16 plus half the distance
    always_comb
    begin
        if (dv_sel_reg)
            abs_d = (dy_reg < 0) ? 25'(-dy_reg) : 25'(dy_reg);
        else
            abs_d = (dx_reg < 0) ? 25'(-dx_reg) : 25'(dx_reg);
        dv_num = (42'(abs_d) << 16) + 42'(dist_reg >> 1);
    end

    // Table port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = pi_reg;
        ram_raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_waddr = count_reg[AW-1:0];
                ram_wdata = '{pos_x: cmd.new_pos_x, pos_y: cmd.new_pos_y,
                              vel_x: cmd.new_vel_x, vel_y: cmd.new_vel_y};
                ram_we    = start && (cmd.kind == KIND_ADD) &&
                            (n_ext < (CW+1)'(MAX_BALLS));
            end
            S_MV_RD, S_RP_RD: ram_raddr = k_reg[AW-1:0];
            S_MV_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[AW-1:0];
                ram_wdata = moved;
            end
            S_P_RDI: ram_raddr = i_reg[AW-1:0];
            S_P_RDJ: ram_raddr = j_reg[AW-1:0];
            S_P_WRI:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[AW-1:0];
                ram_wdata = pi_reg;
            end
            S_P_WRJ:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[AW-1:0];
                ram_wdata = pj_reg;
            end
            default: ram_raddr = '0;
        endcase
    end

    // Sequencer, datapath registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            k_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            wall_l_reg       <= 16'sd0;
            wall_t_reg       <= 16'sd0;
            wall_r_reg       <= 16'sd640;
            wall_b_reg       <= 16'sd480;
            result_valid_reg <= 1'b0;
            dv_sel_reg       <= 1'b0;
            dv_cnt_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            prod_reg         <= mul_p;

            // Register writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_WALL_LEFT:   wall_l_reg <= cfg_data;
                    CFG_WALL_TOP:    wall_t_reg <= cfg_data;
                    CFG_WALL_RIGHT:  wall_r_reg <= cfg_data;
                    CFG_WALL_BOTTOM: wall_b_reg <= cfg_data;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (cmd.kind)
                            KIND_ADD:
                            begin
                                result_valid_reg <= 1'b1;
                                if (n_ext < (CW+1)'(MAX_BALLS))
                                begin
                                    result_reg <= '{disk_index: 4'(count_reg),
                                                    pos_x: cmd.new_pos_x,
                                                    pos_y: cmd.new_pos_y,
                                                    vel_x: cmd.new_vel_x,
                                                    vel_y: cmd.new_vel_y,
                                                    status: STAT_ADDED,
                                                    last: 1'b1};
                                    count_reg <= CW'(n_ext + (CW+1)'(1));
                                end
                                else
                                begin
                                    result_reg <= '{status: STAT_FULL, last: 1'b1,
                                                    default: '0};
                                end
                            end
                            KIND_CLEAR:
                            begin
                                result_valid_reg <= 1'b1;
                                result_reg       <= '{status: STAT_CLEARED, last: 1'b1,
                                                      default: '0};
                                count_reg        <= '0;
                            end
                            KIND_TICK:
                            begin
                                k_reg <= '0;
                                if (count_reg != '0)
                                    state_reg <= S_MV_RD;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end

                // Wall pass
                S_MV_RD: state_reg <= S_MV_WR;
                S_MV_WR:
                begin
                    if (k_inc == n_ext)
                    begin
                        k_reg <= '0;
                        i_reg <= '0;
                        j_reg <= CW'(1);
                        state_reg <= (n_ext >= (CW+1)'(2)) ? S_P_RDI : S_RP_RD;
                    end
                    else
                    begin
                        k_reg     <= CW'(k_inc);
                        state_reg <= S_MV_RD;
                    end
                end

                // Pair pass: load both disks
                S_P_RDI: state_reg <= S_P_RDJ;
                S_P_RDJ:
                begin
                    pi_reg    <= rd_disk;
                    state_reg <= S_P_LDJ;
                end
                S_P_LDJ:
                begin
                    pj_reg    <= rd_disk;
                    state_reg <= S_P_DELTA;
                end
                S_P_DELTA:
                begin
                    dx_reg    <= 26'(pj_reg.pos_x) - 26'(pi_reg.pos_x);
                    dy_reg    <= 26'(pj_reg.pos_y) - 26'(pi_reg.pos_y);
                    state_reg <= S_P_SQX;
                end

                // Squared distance; drop far pairs early
                S_P_SQX:
                begin
                    if (dx_reg > 26'(DIA_L) || dx_reg < -26'(DIA_L) ||
                        dy_reg > 26'(DIA_L) || dy_reg < -26'(DIA_L))
                        state_reg <= S_P_NEXT;
                    else
                        state_reg <= S_P_SQY;
                end
                S_P_SQY:
                begin
                    acc_reg   <= 56'(prod_reg);
                    state_reg <= S_P_D2;
                end
                S_P_D2:
                begin
                    acc_reg   <= acc_reg + 56'(prod_reg);
                    state_reg <= S_P_CHK;
                end
                S_P_CHK:
                begin
                    if (acc_reg == '0 || acc_reg > 56'(DIA_SQ))
                    begin
                        state_reg <= S_P_NEXT;
                    end
                    else
                    begin
                        sq_v_reg   <= acc_reg[SQ_W-1:0];
                        sq_r_reg   <= '0;
                        sq_bit_reg <= SQ_W'(1) << (SQ_W - 2);
                        state_reg  <= S_P_SQRT;
                    end
                end

                // Root, bit by bit, then rounded to nearest
                S_P_SQRT:
                begin
                    if (sq_v_reg >= sq_t)
                    begin
                        sq_v_reg <= sq_v_reg - sq_t;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg == SQ_W'(1))
                        state_reg <= S_P_SQRND;
                end
                S_P_SQRND:
                begin
                    dist_reg   <= (sq_v_reg > sq_r_reg) ? 26'(sq_r_reg + SQ_W'(1))
                                                        : 26'(sq_r_reg);
                    dv_sel_reg <= 1'b0;
                    state_reg  <= S_P_DIVI;
                end

                // Normal components, one quotient bit per step
                S_P_DIVI:
                begin
                    dv_rem_reg <= 27'(dv_num >> QW);
                    dv_low_reg <= dv_num[QW-1:0];
                    dv_q_reg   <= '0;
                    dv_cnt_reg <= '0;
                    dv_neg_reg <= dv_sel_reg ? (dy_reg < 0) : (dx_reg < 0);
                    state_reg  <= S_P_DIV;
                end
                S_P_DIV:
                begin
                    if (dv_t >= 28'(dist_reg))
                    begin
                        dv_rem_reg <= 27'(dv_t - 28'(dist_reg));
                        dv_q_reg   <= {dv_q_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg <= 27'(dv_t);
                        dv_q_reg   <= {dv_q_reg[QW-2:0], 1'b0};
                    end
                    dv_low_reg <= dv_low_reg << 1;
                    dv_cnt_reg <= dv_cnt_reg + 5'd1;
                    if (dv_cnt_reg == 5'(QW - 1))
                        state_reg <= S_P_DIVE;
                end
                S_P_DIVE:
                begin
                    if (dv_sel_reg)
                    begin
                        ny_reg    <= dv_neg_reg ? -q_s : q_s;
                        state_reg <= S_P_M0;
                    end
                    else
                    begin
                        nx_reg     <= dv_neg_reg ? -q_s : q_s;
                        dv_sel_reg <= 1'b1;
                        state_reg  <= S_P_DIVI;
                    end
                end

                // Normal speeds, velocity and push terms
                S_P_M0: state_reg <= S_P_M1;
                S_P_M1:
                begin
                    acc_reg   <= 56'(prod_reg);
                    state_reg <= S_P_M2;
                end
                S_P_M2:
                begin
                    v1n_reg   <= 21'(sum_rnd16);
                    state_reg <= S_P_M3;
                end
                S_P_M3:
                begin
                    acc_reg   <= 56'(prod_reg);
                    state_reg <= S_P_M4;
                end
                S_P_M4:
                begin
                    dvn_reg   <= 22'(sum_rnd16) - 22'(v1n_reg);
                    s2_reg    <= 27'(DIA_L) - $signed({1'b0, dist_reg}) + 27'(ONE_L);
                    state_reg <= S_P_M5;
                end
                S_P_M5: state_reg <= S_P_M6;
                S_P_M6:
                begin
                    cx_reg    <= 24'(prod_rnd16);
                    state_reg <= S_P_M7;
                end
                S_P_M7:
                begin
                    cy_reg    <= 24'(prod_rnd16);
                    state_reg <= S_P_M8;
                end
                S_P_M8:
                begin
                    sx_reg    <= 28'(prod_rnd17);
                    state_reg <= S_P_M9;
                end
                S_P_M9:
                begin
                    sy_reg    <= 28'(prod_rnd17);
                    state_reg <= S_P_UPD;
                end

                // Apply exchange and push, saturated
                S_P_UPD:
                begin
                    pi_reg.vel_x <= sat_vel(40'(pi_reg.vel_x) + 40'(cx_reg));
                    pi_reg.vel_y <= sat_vel(40'(pi_reg.vel_y) + 40'(cy_reg));
                    pj_reg.vel_x <= sat_vel(40'(pj_reg.vel_x) - 40'(cx_reg));
                    pj_reg.vel_y <= sat_vel(40'(pj_reg.vel_y) - 40'(cy_reg));
                    pi_reg.pos_x <= sat_pos(40'(pi_reg.pos_x) - 40'(sx_reg));
                    pi_reg.pos_y <= sat_pos(40'(pi_reg.pos_y) - 40'(sy_reg));
                    pj_reg.pos_x <= sat_pos(40'(pj_reg.pos_x) + 40'(sx_reg));
                    pj_reg.pos_y <= sat_pos(40'(pj_reg.pos_y) + 40'(sy_reg));
                    state_reg    <= S_P_WRI;
                end
                S_P_WRI: state_reg <= S_P_WRJ;
                S_P_WRJ: state_reg <= S_P_NEXT;

                // Advance to the next pair or start the report
                S_P_NEXT:
                begin
                    if (j_inc < n_ext)
                    begin
                        j_reg     <= CW'(j_inc);
                        state_reg <= S_P_RDI;
                    end
                    else if (i_inc2 < n_ext)
                    begin
                        i_reg     <= CW'((CW+1)'(i_reg) + (CW+1)'(1));
                        j_reg     <= CW'(i_inc2);
                        state_reg <= S_P_RDI;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        state_reg <= S_RP_RD;
                    end
                end

                // Report every disk
                S_RP_RD: state_reg <= S_RP_OUT;
                S_RP_OUT:
                begin
                    result_valid_reg <= 1'b1;
                    result_reg       <= '{disk_index: 4'(k_reg),
                                          pos_x: rd_disk.pos_x,
                                          pos_y: rd_disk.pos_y,
                                          vel_x: rd_disk.vel_x,
                                          vel_y: rd_disk.vel_y,
                                          status: STAT_TICK,
                                          last: (k_inc == n_ext)};
                    if (k_inc == n_ext)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= CW'(k_inc);
                        state_reg <= S_RP_RD;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the equal-disk collision block. Directed rows cover the
// special cases, then random add/tick/clear traffic runs against a local
// model of the arena. Every result is checked field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bbc_pkg::*;

    localparam int NDISK   = 16;
    localparam int DIA_PX  = 30;
    localparam int FRACB   = 8;
    localparam int LIMIT   = 8000000;
    localparam int SETTLE  = 40;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        result_valid;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    bouncing_ball_collision_step dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Arena model state
    longint px_m[NDISK];
    longint py_m[NDISK];
    longint vx_m[NDISK];
    longint vy_m[NDISK];
    int     count_m;
    logic signed [15:0] walls_m[4];

    result_t expected_q[$];
    int      errors;
    int      cycles;
    bit      idle_ok;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint clip(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint fdiv(longint a, int s);
        if (a >= 0)
            return a >>> s;
        return -(((-a) + (longint'(1) << s) - 1) >>> s);
    endfunction

    function automatic longint rdiv(longint a, int s);
        return fdiv(a + (longint'(1) << (s - 1)), s);
    endfunction

    function automatic longint root_near(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        if (v > r)
            r = r + 1;
        return r;
    endfunction

    function automatic longint unit_part(longint d, longint dlen);
        longint m;
        longint q;
        m = d < 0 ? -d : d;
        q = ((m << 16) + dlen / 2) / dlen;
        return d < 0 ? -q : q;
    endfunction

    task automatic bounce_axis(inout longint p, inout longint v, input longint lo,
                               input longint hi_w, input longint dia);
        longint x;
        longint hi;
        x = p + v;
        hi = hi_w - dia;
        if (x < lo || x + dia > hi_w)
            v = clip(-v, 16);
        if (x > hi)
            x = hi;
        if (x < lo)
            x = lo;
        p = clip(x, 24);
    endtask

    task automatic resolve_pair(int i, int j, longint dia);
        longint dx, dy, d2, dlen, nx, ny, v1n, v2n, dvn, cx, cy, s2, sx, sy;
        dx = px_m[j] - px_m[i];
        dy = py_m[j] - py_m[i];
        d2 = dx * dx + dy * dy;
        if (d2 == 0 || d2 > dia * dia)
            return;
        dlen = root_near(d2);
        if (dlen == 0)
            return;
        nx = unit_part(dx, dlen);
        ny = unit_part(dy, dlen);
        v1n = rdiv(vx_m[i] * nx + vy_m[i] * ny, 16);
        v2n = rdiv(vx_m[j] * nx + vy_m[j] * ny, 16);
        dvn = v2n - v1n;
        cx = rdiv(dvn * nx, 16);
        cy = rdiv(dvn * ny, 16);
        vx_m[i] = clip(vx_m[i] + cx, 16);
        vy_m[i] = clip(vy_m[i] + cy, 16);
        vx_m[j] = clip(vx_m[j] - cx, 16);
        vy_m[j] = clip(vy_m[j] - cy, 16);
        s2 = dia - dlen + (longint'(1) << FRACB);
        sx = rdiv(s2 * nx, 17);
        sy = rdiv(s2 * ny, 17);
        px_m[i] = clip(px_m[i] - sx, 24);
        py_m[i] = clip(py_m[i] - sy, 24);
        px_m[j] = clip(px_m[j] + sx, 24);
        py_m[j] = clip(py_m[j] + sy, 24);
    endtask

    // Append one expectation at the tail of the queue
    task automatic queue_result(result_t r);
        expected_q.insert(expected_q.size(), r);
    endtask

    // Predict the results of one command and queue them
    task automatic predict_arena(cmd_t c);
        result_t r;
        longint dia, l, t, rt, b;
        r = '0;
        r.last = 1'b1;
        dia = longint'(DIA_PX) << FRACB;
        if (c.kind == KIND_ADD)
        begin
            if (count_m >= NDISK)
                r.status = STAT_FULL;
            else
            begin
                px_m[count_m] = longint'(c.new_pos_x);
                py_m[count_m] = longint'(c.new_pos_y);
                vx_m[count_m] = longint'(c.new_vel_x);
                vy_m[count_m] = longint'(c.new_vel_y);
                r.disk_index = count_m[3:0];
                r.pos_x = c.new_pos_x;
                r.pos_y = c.new_pos_y;
                r.vel_x = c.new_vel_x;
                r.vel_y = c.new_vel_y;
                r.status = STAT_ADDED;
                count_m++;
            end
            queue_result(r);
        end
        else if (c.kind == KIND_CLEAR)
        begin
            count_m = 0;
            r.status = STAT_CLEARED;
            queue_result(r);
        end
        else if (c.kind == KIND_TICK)
        begin
            l = longint'(walls_m[CFG_WALL_LEFT]) * 256;
            t = longint'(walls_m[CFG_WALL_TOP]) * 256;
            rt = longint'(walls_m[CFG_WALL_RIGHT]) * 256;
            b = longint'(walls_m[CFG_WALL_BOTTOM]) * 256;
            for (int i = 0; i < count_m; i++)
            begin
                bounce_axis(px_m[i], vx_m[i], l, rt, dia);
                bounce_axis(py_m[i], vy_m[i], t, b, dia);
            end
            for (int i = 0; i < count_m; i++)
                for (int j = i + 1; j < count_m; j++)
                    resolve_pair(i, j, dia);
            for (int i = 0; i < count_m; i++)
            begin
                r.disk_index = i[3:0];
                r.pos_x = px_m[i][23:0];
                r.pos_y = py_m[i][23:0];
                r.vel_x = vx_m[i][15:0];
                r.vel_y = vy_m[i][15:0];
                r.status = STAT_TICK;
                r.last = (i == count_m - 1);
                queue_result(r);
            end
        end
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result %p", $time, result);
                errors++;
            end
            else
            begin
                result_t e;
                e = expected_q.pop_front();
                if (result !== e)
                begin
                    $display("%0t mismatch exp %p act %p", $time, e, result);
                    errors++;
                end
            end
        end
    end

    function automatic bit take_gap();
        return idle_ok && ($urandom_range(99) < 36);
    endfunction

    // Issue one command and hold it until the block takes it
    task automatic issue(cmd_t c);
        while (take_gap())
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_arena(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_wall(logic [1:0] idx, logic signed [15:0] v);
        while (take_gap())
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        walls_m[idx] = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic cmd_t mk(logic [1:0] k, int x, int y, int vx, int vy);
        cmd_t c;
        c.kind = k;
        c.new_pos_x = 24'(x);
        c.new_pos_y = 24'(y);
        c.new_vel_x = 16'(vx);
        c.new_vel_y = 16'(vy);
        return c;
    endfunction

    // Random disk near the arena so that walls and collisions are hit often
    function automatic cmd_t rand_add();
        cmd_t c;
        c.kind = KIND_ADD;
        if ($urandom_range(9) == 0)
        begin
            c.new_pos_x = 24'($urandom);
            c.new_pos_y = 24'($urandom);
            c.new_vel_x = 16'($urandom);
            c.new_vel_y = 16'($urandom);
        end
        else
        begin
            c.new_pos_x = 24'(int'($urandom_range(20000))
                              + 250 * int'(walls_m[CFG_WALL_LEFT]));
            c.new_pos_y = 24'(int'($urandom_range(20000))
                              + 250 * int'(walls_m[CFG_WALL_TOP]));
            c.new_vel_x = 16'(int'($urandom_range(2000)) - 1000);
            c.new_vel_y = 16'(int'($urandom_range(2000)) - 1000);
        end
        return c;
    endfunction

    // Directed rows: command plus, where obvious, the fixed result
    typedef struct {
        cmd_t    c;
        bit      fixed;
        result_t r;
    } row_t;

    row_t rows[$];

    task automatic add_row(cmd_t c, bit f, logic [1:0] st);
        row_t w;
        w.c = c;
        w.fixed = f;
        w.r = '0;
        w.r.status = st;
        w.r.last = 1'b1;
        if (f && st == STAT_ADDED)
        begin
            w.r.pos_x = c.new_pos_x;
            w.r.pos_y = c.new_pos_y;
            w.r.vel_x = c.new_vel_x;
            w.r.vel_y = c.new_vel_y;
        end
        rows.insert(rows.size(), w);
    endtask

    initial
    begin
        int k;
        errors = 0;
        cycles = 0;
        idle_ok = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WALL_LEFT;
        cfg_data = '0;
        count_m = 0;
        walls_m[CFG_WALL_LEFT] = 0;
        walls_m[CFG_WALL_TOP] = 0;
        walls_m[CFG_WALL_RIGHT] = 640;
        walls_m[CFG_WALL_BOTTOM] = 480;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty tick, unused kind, extremes, collisions, full
        add_row(mk(KIND_TICK, 0, 0, 0, 0), 0, STAT_TICK);
        add_row(mk(KIND_NONE, -1, -1, -1, -1), 0, STAT_TICK);
        add_row(mk(KIND_ADD, 8388607, -8388608, 32767, -32768), 1, STAT_ADDED);
        add_row(mk(KIND_ADD, -8388608, 8388607, -32768, 32767), 1, STAT_ADDED);
        add_row(mk(KIND_TICK, 0, 0, 0, 0), 0, STAT_TICK);
        add_row(mk(KIND_CLEAR, 0, 0, 0, 0), 1, STAT_CLEARED);
        add_row(mk(KIND_ADD, 1000, 1000, 300, 0), 1, STAT_ADDED);
        add_row(mk(KIND_ADD, 7000, 1000, -300, 0), 1, STAT_ADDED);
        add_row(mk(KIND_ADD, 1000, 1000, 0, 100), 1, STAT_ADDED);
        add_row(mk(KIND_ADD, 160000, 100, 2000, -2000), 1, STAT_ADDED);
        add_row(mk(KIND_TICK, 0, 0, 0, 0), 0, STAT_TICK);
        add_row(mk(KIND_TICK, 0, 0, 0, 0), 0, STAT_TICK);
        for (int i = 0; i < 12; i++)
            add_row(mk(KIND_ADD, 2000 + 5000 * i, 3000 + 1000 * i, -i * 50, i * 70),
                    1, STAT_ADDED);
        add_row(mk(KIND_ADD, 5, 5, 5, 5), 1, STAT_FULL);
        add_row(mk(KIND_TICK, 0, 0, 0, 0), 0, STAT_TICK);

        k = 0;
        foreach (rows[n])
        begin
            if (rows[n].fixed)
            begin
                if (rows[n].r.status == STAT_ADDED)
                    rows[n].r.disk_index = k[3:0];
                if (rows[n].r.status == STAT_ADDED)
                    k++;
                if (rows[n].r.status == STAT_CLEARED)
                    k = 0;
            end
            issue(rows[n].c);
            if (rows[n].fixed && expected_q.size() != 0
                && expected_q[$] !== rows[n].r)
            begin
                $display("%0t mismatch exp %p act %p", $time, rows[n].r, expected_q[$]);
                errors++;
            end
        end

        // Hold off until the table has reported everything
        drain();

        // Random phases under several wall settings, extremes included
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_wall(CFG_WALL_LEFT, 16'sh8000);
                    write_wall(CFG_WALL_TOP, 16'sh8000);
                    write_wall(CFG_WALL_RIGHT, 16'sd32767);
                    write_wall(CFG_WALL_BOTTOM, 16'sd32767);
                end
                1:
                begin
                    write_wall(CFG_WALL_LEFT, 16'sd0);
                    write_wall(CFG_WALL_TOP, 16'sd0);
                    write_wall(CFG_WALL_RIGHT, 16'sd100);
                    write_wall(CFG_WALL_BOTTOM, 16'sd80);
                end
                2:
                begin
                    // arena narrower than a disk
                    write_wall(CFG_WALL_LEFT, 16'sd10);
                    write_wall(CFG_WALL_TOP, -16'sd5);
                    write_wall(CFG_WALL_RIGHT, 16'sd20);
                    write_wall(CFG_WALL_BOTTOM, 16'sd0);
                end
                default:
                begin
                    write_wall(CFG_WALL_LEFT, 16'($urandom_range(40)));
                    write_wall(CFG_WALL_TOP, 16'($urandom_range(40)));
                    write_wall(CFG_WALL_RIGHT, 16'sd200);
                    write_wall(CFG_WALL_BOTTOM, 16'sd150);
                end
            endcase
            idle_ok = (ph != 1);
            issue(mk(KIND_CLEAR, 0, 0, 0, 0));
            for (int n = 0; n < 28; n++)
            begin
                k = $urandom_range(99);
                if (k < 45)
                    issue(rand_add());
                else if (k < 92)
                    issue(mk(KIND_TICK, $urandom, $urandom, $urandom, $urandom));
                else if (k < 97)
                    issue(mk(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom));
                else
                    issue(mk(KIND_NONE, $urandom, $urandom, $urandom, $urandom));
            end
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
